// ===== rtl/core/htco_pkg.sv =====
// shared types and codes for the head-tracking channel override block
`timescale 1ns / 1ps

package htco_pkg;

  // input operation codes, carried on s_tuser
  localparam logic [2:0] OP_PACKET_START = 3'd0;
  localparam logic [2:0] OP_PAYLOAD_WORD = 3'd1;
  localparam logic [2:0] OP_PACKET_END   = 3'd2;
  localparam logic [2:0] OP_OVERRIDE     = 3'd3;
  localparam logic [2:0] OP_PUBLISH      = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_START_CHANNEL = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_STALE_TIMEOUT = 1'b1;

  localparam logic [15:0] NO_UPDATE_WORD      = 16'hffff;
  localparam logic [15:0] STALE_TIMEOUT_RESET = 16'd1000;

  // one result transfer
  typedef struct packed {
    logic [7:0]  packed_byte;
    logic [31:0] channel_value;
    logic        last_of_run;
  } result_t;

endpackage

// ===== rtl/core/head_tracking_channel_override.sv =====
// top level of the head-tracking channel override block
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+--------------------------------------------
//  s_       | in  | s_tvalid/s_tready | s_tuser op, s_tdata time/word/index/value
//  m_       | out | m_tvalid/m_tready | m_tdata value/byte, m_tlast last of run
//  cfg_     | in  | cfg_we            | cfg_addr register index, cfg_wdata value
//
// packet_start, payload word and packet_end are handled in the idle state.
// an override reads the value memory, then loads the result into the output stage.
// a publish reads the channels from the value memory in turn and emits each packed
// byte as it fills; an unchanged table returns to idle without sending anything.
// one item is in work at a time; a stalled m_ side holds the block in its current step.
// rst is synchronous; it clears the valid bits, timestamps and start channel and resets the stale timeout.
`timescale 1ns / 1ps

module head_tracking_channel_override #(
  parameter int NUM_CHANNELS = 16,
  parameter int PACK_BITS    = 11
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // time_ms [31:0], payload_word [47:32],
                                 // channel_index [51:48], channel_value_in [83:52]
  input  logic [2:0]  s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // channel_value [31:0], packed_byte [39:32]
  output logic        m_tlast,   // last_of_run
  input  logic        cfg_we,
  input  logic [htco_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int AW         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PW         = $clog2(NUM_CHANNELS + 1);
  localparam int PACK_BYTES = (NUM_CHANNELS * PACK_BITS) / 8;
  localparam int BCW        = (PACK_BYTES > 1) ? $clog2(PACK_BYTES) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_OVR,
    S_PUB_LOAD,
    S_PUB_EMIT
  } state_t;

  state_t            state;
  logic [NUM_CHANNELS-1:0] valid_bits;
  logic [PW-1:0]     fill_ptr;
  logic [31:0]       last_valid_time;
  logic [31:0]       last_sent_time;
  logic [3:0]        start_channel;
  logic [15:0]       stale_timeout;
  logic [31:0]       time_r;
  logic [31:0]       chan_in_r;
  logic [AW-1:0]     idx_addr_r;
  logic              idx_ok_r;
  logic [PW-1:0]     ch;
  logic [23:0]       acc;
  logic [4:0]        bits;
  logic [BCW-1:0]    bcnt;

  // input fields
  logic [31:0] in_time;
  logic [15:0] in_word;
  logic [3:0]  in_idx;
  logic [31:0] in_chan;
  assign in_time = s_tdata[31:0];
  assign in_word = s_tdata[47:32];
  assign in_idx  = s_tdata[51:48];
  assign in_chan = s_tdata[83:52];

  logic accept;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  logic [5:0] idx_wide;
  logic [5:0] start_wide;
  logic [5:0] fill_start;
  assign idx_wide   = {2'b00, in_idx};
  assign start_wide = {2'b00, start_channel};
  assign fill_start = (start_wide >= 6'(NUM_CHANNELS)) ? 6'(NUM_CHANNELS) : start_wide;

  logic fill_ok;
  assign fill_ok = fill_ptr < PW'(NUM_CHANNELS);

  logic [PW-1:0] ch_next;
  assign ch_next = ch + 1'b1;

  // value memory access
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  always_comb begin
    ram_we    = accept && (s_tuser == htco_pkg::OP_PAYLOAD_WORD) && fill_ok &&
                (in_word != htco_pkg::NO_UPDATE_WORD);
    ram_re    = 1'b0;
    ram_raddr = idx_wide[AW-1:0];
    if (accept && (s_tuser == htco_pkg::OP_OVERRIDE)) begin
      ram_re = 1'b1;
    end else if (accept && (s_tuser == htco_pkg::OP_PUBLISH)) begin
      ram_re    = 1'b1;
      ram_raddr = '0;
    end else if (state == S_PUB_LOAD) begin
      ram_re    = ch_next < PW'(NUM_CHANNELS);
      ram_raddr = ch_next[AW-1:0];
    end
  end

  htco_value_ram #(
    .DEPTH (NUM_CHANNELS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_ptr[AW-1:0]),
    .wdata (in_word),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // override decision
  logic [31:0] age;
  logic        hit;
  assign age = time_r - last_valid_time;
  assign hit = (age <= {16'd0, stale_timeout}) && idx_ok_r && valid_bits[idx_addr_r];

  // publish packing
  logic [15:0] pack_val;
  logic [23:0] acc_load;
  logic [4:0]  bits_left;
  assign pack_val  = valid_bits[ch[AW-1:0]] ?
                     (ram_rdata & 16'((32'd1 << PACK_BITS) - 32'd1)) : 16'd0;
  assign acc_load  = acc | ({8'd0, pack_val} << bits);
  assign bits_left = bits - 5'd8;

  // output stage
  logic              out_free;
  logic              out_load;
  htco_pkg::result_t out_din;

  always_comb begin
    out_load              = 1'b0;
    out_din.channel_value = hit ? {16'd0, ram_rdata} : chan_in_r;
    out_din.packed_byte   = 8'd0;
    out_din.last_of_run   = 1'b1;
    if (state == S_OVR) begin
      out_load = 1'b1;
    end else if ((state == S_PUB_EMIT) && (bits >= 5'd8)) begin
      out_load              = 1'b1;
      out_din.channel_value = 32'd0;
      out_din.packed_byte   = acc[7:0];
      out_din.last_of_run   = bcnt == BCW'(PACK_BYTES - 1);
    end
  end

  htco_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .din      (out_din),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      valid_bits      <= '0;
      fill_ptr        <= '0;
      last_valid_time <= '0;
      last_sent_time  <= '0;
      start_channel   <= '0;
      stale_timeout   <= htco_pkg::STALE_TIMEOUT_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          htco_pkg::CFG_START_CHANNEL: start_channel <= cfg_wdata[3:0];
          htco_pkg::CFG_STALE_TIMEOUT: stale_timeout <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            time_r     <= in_time;
            chan_in_r  <= in_chan;
            idx_addr_r <= idx_wide[AW-1:0];
            idx_ok_r   <= idx_wide < 6'(NUM_CHANNELS);
            unique case (s_tuser)
              htco_pkg::OP_PACKET_START: begin
                valid_bits <= '0;
                fill_ptr   <= fill_start[PW-1:0];
              end
              htco_pkg::OP_PAYLOAD_WORD: begin
                if (fill_ok) begin
                  valid_bits[fill_ptr[AW-1:0]] <= in_word != htco_pkg::NO_UPDATE_WORD;
                  fill_ptr <= fill_ptr + 1'b1;
                end
              end
              htco_pkg::OP_PACKET_END: begin
                last_valid_time <= in_time;
              end
              htco_pkg::OP_OVERRIDE: begin
                state <= S_OVR;
              end
              htco_pkg::OP_PUBLISH: begin
                // unchanged table since last publish sends nothing
                if (last_sent_time != last_valid_time) begin
                  last_sent_time <= last_valid_time;
                  ch    <= '0;
                  acc   <= '0;
                  bits  <= '0;
                  bcnt  <= '0;
                  state <= S_PUB_LOAD;
                end
              end
              default: ;
            endcase
          end
        end
        S_OVR: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_PUB_LOAD: begin
          acc   <= acc_load;
          bits  <= bits + 5'(PACK_BITS);
          ch    <= ch_next;
          state <= S_PUB_EMIT;
        end
        S_PUB_EMIT: begin
          if (bits >= 5'd8) begin
            if (out_free) begin
              acc  <= acc >> 8;
              bits <= bits_left;
              bcnt <= bcnt + 1'b1;
              if (bits_left < 5'd8) begin
                state <= (ch == PW'(NUM_CHANNELS)) ? S_IDLE : S_PUB_LOAD;
              end
            end
          end else begin
            // bits short of a byte carry into the next channel; after the last channel they are dropped
            state <= (ch == PW'(NUM_CHANNELS)) ? S_IDLE : S_PUB_LOAD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/htco_value_ram.sv =====
// channel value store: one write port, one read port with registered data
`timescale 1ns / 1ps

module htco_value_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/htco_out_reg.sv =====
// output register stage for result transfers
`timescale 1ns / 1ps

module htco_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  htco_pkg::result_t din,
  output logic             free,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [39:0]      m_tdata,   // channel_value [31:0], packed_byte [39:32]
  output logic             m_tlast    // last_of_run
);

  htco_pkg::result_t hold;
  logic              full;

  // slot can take a new result when empty or being drained this cycle
  assign free = !full || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (free) begin
      full <= load;
    end
    if (free && load) begin
      hold <= din;
    end
  end

  assign m_tvalid = full;
  assign m_tdata  = {hold.packed_byte, hold.channel_value};
  assign m_tlast  = hold.last_of_run;

endmodule

// ===== rtl/core/htco_checker.sv =====
// port-level checks for the head-tracking channel override block
`timescale 1ns / 1ps

module htco_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [2:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);

  // a stalled result transfer keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered after reset");

  // an override occupies the block for its memory read
  a_override_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == htco_pkg::OP_OVERRIDE) |=> !s_tready)
    else $error("input taken during override lookup");

  // a nonzero channel value only comes from an override, a single last transfer
  a_override_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[31:0] != 32'd0) |-> m_tlast && (m_tdata[39:32] == 8'd0))
    else $error("override result mixed with packed byte");

endmodule

bind head_tracking_channel_override htco_checker u_htco_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
